>>> hdl/rtk_pkg.sv
// ----------------------------------------------------------------------------
// rtk_pkg
// Shared types and constants for the rapid trigger key tracker.
// ----------------------------------------------------------------------------
package rtk_pkg;

	localparam int SAMPLE_BITS_DEFAULT = 12;

	localparam int CFG_INDEX_BITS = 2;

	localparam int RST_ACTUATION_LEVEL = 2048;
	localparam int RST_RELEASE_LEVEL   = 1024;
	localparam int RST_SENSITIVITY     = 100;

	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

	localparam cfg_index_t REG_ACTUATION_LEVEL = 2'd0;
	localparam cfg_index_t REG_RELEASE_LEVEL   = 2'd1;
	localparam cfg_index_t REG_SENSITIVITY     = 2'd2;

	typedef enum logic [1:0] {
		MODE_IDLE      = 2'd0,
		MODE_ACTIVE    = 2'd1,
		MODE_RELEASING = 2'd2
	} key_mode_t;

	typedef enum logic [1:0] {
		EVENT_NONE    = 2'd0,
		EVENT_PRESS   = 2'd1,
		EVENT_RELEASE = 2'd2
	} key_event_t;

	typedef struct packed {
		key_event_t key_event;
		key_mode_t  key_mode;
	} step_result_t;

endpackage

>>> hdl/rtk_ifs.sv
// ----------------------------------------------------------------------------
// rtk_ifs
// Valid/ready channels: depth samples, key results and register writes.
// ----------------------------------------------------------------------------
interface rtk_sample_if #(
	parameter int SAMPLE_BITS = rtk_pkg::SAMPLE_BITS_DEFAULT
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] depth_sample;

	modport source (output valid, output depth_sample, input ready);
	modport sink (input valid, input depth_sample, output ready);
endinterface

interface rtk_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] key_event;
	logic [1:0] key_mode;

	modport source (output valid, output key_event, output key_mode, input ready);
	modport sink (input valid, input key_event, input key_mode, output ready);
endinterface

interface rtk_cfg_if #(
	parameter int SAMPLE_BITS = rtk_pkg::SAMPLE_BITS_DEFAULT
);
	logic                              valid;
	logic                              ready;
	logic [rtk_pkg::CFG_INDEX_BITS-1:0] index;
	logic [SAMPLE_BITS-1:0]            data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/rtk_cfg_regs.sv
// ----------------------------------------------------------------------------
// rtk_cfg_regs
// Threshold registers: actuation level, release level, sensitivity.
// ----------------------------------------------------------------------------
module rtk_cfg_regs #(
	parameter int SAMPLE_BITS = rtk_pkg::SAMPLE_BITS_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	rtk_cfg_if.sink                cfg,
	output logic [SAMPLE_BITS-1:0] actuation_level,
	output logic [SAMPLE_BITS-1:0] release_level,
	output logic [SAMPLE_BITS-1:0] sensitivity
);
	import rtk_pkg::*;

	logic [SAMPLE_BITS-1:0] actuation_q;
	logic [SAMPLE_BITS-1:0] release_q;
	logic [SAMPLE_BITS-1:0] sens_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			actuation_q <= SAMPLE_BITS'(RST_ACTUATION_LEVEL);
			release_q   <= SAMPLE_BITS'(RST_RELEASE_LEVEL);
			sens_q      <= SAMPLE_BITS'(RST_SENSITIVITY);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ACTUATION_LEVEL: actuation_q <= cfg.data;
				REG_RELEASE_LEVEL:   release_q   <= cfg.data;
				REG_SENSITIVITY:     sens_q      <= cfg.data;
				default: ;
			endcase
		end
	end

	assign actuation_level = actuation_q;
	assign release_level   = release_q;
	assign sensitivity     = sens_q;

endmodule

>>> hdl/rtk_tracker.sv
// ----------------------------------------------------------------------------
// rtk_tracker
// Key mode state machine with peak/trough tracking; one sample per step.
// ----------------------------------------------------------------------------
module rtk_tracker #(
	parameter int SAMPLE_BITS = rtk_pkg::SAMPLE_BITS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step_en,
	input  logic [SAMPLE_BITS-1:0] depth,
	input  logic [SAMPLE_BITS-1:0] actuation_level,
	input  logic [SAMPLE_BITS-1:0] release_level,
	input  logic [SAMPLE_BITS-1:0] sensitivity,
	output rtk_pkg::step_result_t  result
);
	import rtk_pkg::*;

	key_mode_t              mode_q, mode_d;
	logic [SAMPLE_BITS-1:0] deepest_q, deepest_d;
	logic [SAMPLE_BITS-1:0] shallowest_q, shallowest_d;

	logic                   at_actuation;
	logic                   at_release;
	logic                   new_peak;
	logic                   new_trough;
	logic                   drop_hit;
	logic                   rise_hit;
	logic [SAMPLE_BITS-1:0] drop;
	logic [SAMPLE_BITS-1:0] rise;

	// drop only used when below peak, rise only when above trough: no wrap
	always_comb begin
		drop         = deepest_q - depth;
		rise         = depth - shallowest_q;
		at_actuation = depth >= actuation_level;
		at_release   = depth <= release_level;
		new_peak     = depth >= deepest_q;
		new_trough   = depth <= shallowest_q;
		drop_hit     = drop >= sensitivity;
		rise_hit     = rise >= sensitivity;
	end

	// next state
	always_comb begin
		mode_d       = mode_q;
		deepest_d    = deepest_q;
		shallowest_d = shallowest_q;
		case (mode_q)
			MODE_ACTIVE: begin
				if (new_peak) begin
					deepest_d = depth;
				end else if (at_release) begin
					mode_d = MODE_IDLE;
				end else if (drop_hit) begin
					mode_d       = MODE_RELEASING;
					shallowest_d = depth;
				end
			end
			MODE_RELEASING: begin
				if (new_trough) begin
					shallowest_d = depth;
					if (at_release) begin
						mode_d = MODE_IDLE;
					end
				end else if (rise_hit) begin
					mode_d    = MODE_ACTIVE;
					deepest_d = depth;
				end
			end
			default: begin
				if (at_actuation) begin
					mode_d       = MODE_ACTIVE;
					deepest_d    = depth;
					shallowest_d = depth;
				end
			end
		endcase
	end

	// outputs
	always_comb begin
		result.key_mode  = mode_d;
		result.key_event = EVENT_NONE;
		case (mode_q)
			MODE_ACTIVE: begin
				if (!new_peak && (at_release || drop_hit)) begin
					result.key_event = EVENT_RELEASE;
				end
			end
			MODE_RELEASING: begin
				if (!new_trough && rise_hit) begin
					result.key_event = EVENT_PRESS;
				end
			end
			default: begin
				if (at_actuation) begin
					result.key_event = EVENT_PRESS;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
		end else if (step_en) begin
			mode_q <= mode_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			deepest_q    <= deepest_d;
			shallowest_q <= shallowest_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_press_enters_active: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && result.key_event == EVENT_PRESS |=> mode_q == MODE_ACTIVE)
		else $error("press without entering active");

	a_idle_holds_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && mode_q == MODE_IDLE && result.key_event == EVENT_NONE
		|=> mode_q == MODE_IDLE)
		else $error("idle left without press");

	a_mode_holds_unstepped: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(mode_q))
		else $error("mode changed without a step");

	a_peak_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && mode_q == MODE_ACTIVE && result.key_mode == MODE_ACTIVE
		|=> deepest_q >= $past(depth))
		else $error("peak below a sample seen while active");
`endif

endmodule

>>> hdl/rapid_trigger_key_tracker_top.sv
// ----------------------------------------------------------------------------
// rapid_trigger_key_tracker_top
// Rapid trigger tracker for an analog key: press/release events per sample.
// ----------------------------------------------------------------------------
// One result word per depth sample word, one word per cycle sustained while
// the receiver keeps ready high. A sample is registered on accept in the
// sample register, evaluated against the mode, peak and trough state and,
// unless the result register is still held by the receiver, lands in the
// result register. The result register decouples the two sides: one new
// sample is taken while a result waits, then input stalls.
// The user must make threshold writes through the cfg channel (always ready)
// only while no sample is in flight; the block does not enforce this.
module rapid_trigger_key_tracker_top #(
	parameter int SAMPLE_BITS = rtk_pkg::SAMPLE_BITS_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	rtk_sample_if.sink    samples,
	rtk_result_if.source  results,
	rtk_cfg_if.sink       cfg
);
	import rtk_pkg::*;

	logic [SAMPLE_BITS-1:0] actuation_level;
	logic [SAMPLE_BITS-1:0] release_level;
	logic [SAMPLE_BITS-1:0] sensitivity;

	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] depth_s1;
	logic                   advance;
	step_result_t           step_result;

	logic                   out_valid_q;
	step_result_t           out_q;

	rtk_cfg_regs #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_cfg_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.actuation_level (actuation_level),
		.release_level   (release_level),
		.sensitivity     (sensitivity)
	);

	assign advance       = valid_s1 && (!out_valid_q || results.ready);
	assign samples.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			depth_s1 <= samples.depth_sample;
		end
	end

	rtk_tracker #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_tracker (
		.clk             (clk),
		.arst_n          (arst_n),
		.step_en         (advance),
		.depth           (depth_s1),
		.actuation_level (actuation_level),
		.release_level   (release_level),
		.sensitivity     (sensitivity),
		.result          (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= step_result;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.key_event = out_q.key_event;
	assign results.key_mode  = out_q.key_mode;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rapid trigger key tracker.
// ----------------------------------------------------------------------------
// Depth words go in through the sample channel. A directed table covers the
// threshold edges, zero and full sensitivity, the release level at or above
// the actuation level, and a write to the unused register index. Random
// key strokes follow over several threshold settings, with bursty input, a
// stalling receiver and one long hold-off. Every result word is checked
// against an in-bench tracker of mode, peak and trough or a table row's hand-typed result.
// ----------------------------------------------------------------------------
module tb;
	import rtk_pkg::*;

	localparam int DW              = SAMPLE_BITS_DEFAULT;
	localparam int DEPTH_MAX       = (1 << DW) - 1;
	localparam int SETTLE_CYCLES   = 4;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int PHASES          = 8;
	localparam int WORDS_PER_PHASE = 160;

	localparam cfg_index_t REG_UNUSED = 2'd3;

	typedef logic [DW-1:0] depth_t;

	typedef enum logic {
		ROW_SAMPLE,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		cfg_index_t idx;
		depth_t     val;
		logic       fixed;
		key_event_t ev;
		key_mode_t  md;
	} stim_row_t;

	logic clk;
	logic arst_n;

	rtk_sample_if #(.SAMPLE_BITS(DW)) smp_ch ();
	rtk_result_if                     res_ch ();
	rtk_cfg_if #(.SAMPLE_BITS(DW))    cfg_ch ();

	rapid_trigger_key_tracker_top #(.SAMPLE_BITS(DW)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(smp_ch),
		.results(res_ch),
		.cfg(cfg_ch)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// tracker state and thresholds
	key_mode_t trk_mode    = MODE_IDLE;
	depth_t    trk_peak    = '0;
	depth_t    trk_trough  = '0;
	depth_t    lvl_actuate = depth_t'(RST_ACTUATION_LEVEL);
	depth_t    lvl_release = depth_t'(RST_RELEASE_LEVEL);
	depth_t    lvl_sens    = depth_t'(RST_SENSITIVITY);

	step_result_t key_results_due[$];

	// table rows with a hand-typed result override the tracker
	logic       pin_on;
	key_event_t pin_ev;
	key_mode_t  pin_md;

	int mismatches;
	int n_words;
	int n_results;
	int n_writes;
	int n_press;
	int n_release;
	int n_settings;
	int hold_asks;
	int stall_cycles;

	function automatic step_result_t track_depth(input depth_t d);
		step_result_t r;
		r.key_event = EVENT_NONE;
		case (trk_mode)
			MODE_ACTIVE: begin
				if (d >= trk_peak) begin
					trk_peak = d;
				end else if (d <= lvl_release) begin
					trk_mode    = MODE_IDLE;
					r.key_event = EVENT_RELEASE;
				end else if (trk_peak - d >= lvl_sens) begin
					trk_mode    = MODE_RELEASING;
					trk_trough  = d;
					r.key_event = EVENT_RELEASE;
				end
			end
			MODE_RELEASING: begin
				if (d <= trk_trough) begin
					trk_trough = d;
					if (d <= lvl_release)
						trk_mode = MODE_IDLE;
				end else if (d - trk_trough >= lvl_sens) begin
					trk_mode    = MODE_ACTIVE;
					trk_peak    = d;
					r.key_event = EVENT_PRESS;
				end
			end
			default: begin
				if (d >= lvl_actuate) begin
					trk_mode    = MODE_ACTIVE;
					trk_peak    = d;
					trk_trough  = d;
					r.key_event = EVENT_PRESS;
				end
			end
		endcase
		r.key_mode = trk_mode;
		return r;
	endfunction

	function automatic stim_row_t row_fixed(input depth_t v, input key_event_t e,
			input key_mode_t m);
		return {ROW_SAMPLE, REG_ACTUATION_LEVEL, v, 1'b1, e, m};
	endfunction

	function automatic stim_row_t row_free(input depth_t v);
		return {ROW_SAMPLE, REG_ACTUATION_LEVEL, v, 1'b0, EVENT_NONE, MODE_IDLE};
	endfunction

	function automatic stim_row_t row_reg(input cfg_index_t i, input depth_t v);
		return {ROW_WRITE, i, v, 1'b0, EVENT_NONE, MODE_IDLE};
	endfunction

	// monitor: register writes, sample accepts, result checks, watchdog
	always @(posedge clk) begin : monitor
		step_result_t want;
		bit           moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_ACTUATION_LEVEL: lvl_actuate = cfg_ch.data;
					REG_RELEASE_LEVEL:   lvl_release = cfg_ch.data;
					REG_SENSITIVITY:     lvl_sens    = cfg_ch.data;
					default: ;
				endcase
				n_writes++;
				moved = 1'b1;
			end
			if (smp_ch.valid && smp_ch.ready) begin
				want = track_depth(smp_ch.depth_sample);
				if (pin_on) begin
					want.key_event = pin_ev;
					want.key_mode  = pin_md;
				end
				key_results_due.push_back(want);
				n_words++;
				moved = 1'b1;
			end
			if (res_ch.valid && res_ch.ready) begin
				moved = 1'b1;
				n_results++;
				if (res_ch.key_event == EVENT_PRESS)
					n_press++;
				if (res_ch.key_event == EVENT_RELEASE)
					n_release++;
				if (key_results_due.size() == 0) begin
					$error("unexpected result word: key_event %0d key_mode %0d",
						res_ch.key_event, res_ch.key_mode);
					mismatches++;
				end else begin
					want = key_results_due.pop_front();
					if (res_ch.key_event !== want.key_event) begin
						$error("key_event: expected %0d, got %0d", want.key_event,
							res_ch.key_event);
						mismatches++;
					end
					if (res_ch.key_mode !== want.key_mode) begin
						$error("key_mode: expected %0d, got %0d", want.key_mode,
							res_ch.key_mode);
						mismatches++;
					end
				end
			end
			if (moved)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// receiver: changing stall styles, plus a long hold-off on request
	initial begin : receiver
		int style;
		int cnt;
		int holds_done;
		style      = 0;
		cnt        = 0;
		holds_done = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			cnt++;
			if (hold_asks != holds_done) begin
				holds_done++;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				if (cnt % 48 == 0)
					style = $urandom_range(0, 3);
				case (style)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= $urandom_range(0, 1);
					2: res_ch.ready <= ($urandom_range(0, 3) == 0);
					default: res_ch.ready <= (cnt % 3 != 0);
				endcase
			end
		end
	end

	task automatic send_depth(input depth_t d, input logic fixed, input key_event_t e,
			input key_mode_t m);
		@(negedge clk);
		smp_ch.valid        <= 1'b1;
		smp_ch.depth_sample <= d;
		pin_on              <= fixed;
		pin_ev              <= e;
		pin_md              <= m;
		do @(posedge clk); while (!smp_ch.ready);
	endtask

	task automatic write_reg(input cfg_index_t i, input depth_t v);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= i;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain_results();
		@(negedge clk);
		smp_ch.valid <= 1'b0;
		while (key_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		stim_row_t rows[$];
		depth_t    d;
		int        pos;
		int        target;
		int        span;
		int        stride;
		int        burst_left;
		int        gap;
		int        act;
		int        rel;
		int        sens;

		arst_n              = 1'b0;
		smp_ch.valid        = 1'b0;
		smp_ch.depth_sample = '0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = REG_ACTUATION_LEVEL;
		cfg_ch.data         = '0;
		pin_on              = 1'b0;
		pin_ev              = EVENT_NONE;
		pin_md              = MODE_IDLE;
		mismatches          = 0;
		n_words             = 0;
		n_results           = 0;
		n_writes            = 0;
		n_press             = 0;
		n_release           = 0;
		n_settings          = 1;
		hold_asks           = 0;
		stall_cycles        = 0;

		// reset thresholds: actuate 2048, release 1024, sensitivity 100
		rows.push_back(row_fixed(12'd0,    EVENT_NONE,    MODE_IDLE));
		rows.push_back(row_fixed(12'd2047, EVENT_NONE,    MODE_IDLE));
		rows.push_back(row_fixed(12'd2048, EVENT_PRESS,   MODE_ACTIVE));
		rows.push_back(row_fixed(12'd4095, EVENT_NONE,    MODE_ACTIVE));
		rows.push_back(row_fixed(12'd3996, EVENT_NONE,    MODE_ACTIVE));
		rows.push_back(row_fixed(12'd3995, EVENT_RELEASE, MODE_RELEASING));
		rows.push_back(row_fixed(12'd4094, EVENT_NONE,    MODE_RELEASING));
		rows.push_back(row_fixed(12'd4095, EVENT_PRESS,   MODE_ACTIVE));
		rows.push_back(row_fixed(12'd1024, EVENT_RELEASE, MODE_IDLE));
		rows.push_back(row_fixed(12'd4095, EVENT_PRESS,   MODE_ACTIVE));
		rows.push_back(row_free(12'd2000));
		rows.push_back(row_fixed(12'd1024, EVENT_NONE,    MODE_IDLE));
		// zero sensitivity
		rows.push_back(row_reg(REG_SENSITIVITY, 12'd0));
		rows.push_back(row_fixed(12'd3000, EVENT_PRESS,   MODE_ACTIVE));
		rows.push_back(row_fixed(12'd3000, EVENT_NONE,    MODE_ACTIVE));
		rows.push_back(row_fixed(12'd2999, EVENT_RELEASE, MODE_RELEASING));
		rows.push_back(row_fixed(12'd3000, EVENT_PRESS,   MODE_ACTIVE));
		// release level above actuation level, full sensitivity
		rows.push_back(row_reg(REG_ACTUATION_LEVEL, 12'd100));
		rows.push_back(row_reg(REG_RELEASE_LEVEL, 12'd200));
		rows.push_back(row_reg(REG_SENSITIVITY, 12'd4095));
		rows.push_back(row_free(12'd150));
		rows.push_back(row_free(12'd100));
		rows.push_back(row_free(12'd99));
		// unused index must leave actuation at 100
		rows.push_back(row_reg(REG_UNUSED, 12'd0));
		rows.push_back(row_free(12'd0));
		rows.push_back(row_reg(REG_ACTUATION_LEVEL, 12'd0));
		rows.push_back(row_fixed(12'd0, EVENT_PRESS, MODE_ACTIVE));
		rows.push_back(row_free(12'd4095));
		rows.push_back(row_free(12'd0));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_WRITE) begin
				drain_results();
				write_reg(rows[i].idx, rows[i].val);
				n_settings++;
			end else begin
				send_depth(rows[i].val, rows[i].fixed, rows[i].ev, rows[i].md);
			end
		end

		pos        = 0;
		target     = 0;
		burst_left = 0;
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			case (ph)
				1: begin
					act  = DEPTH_MAX;
					rel  = 0;
					sens = 0;
				end
				2: begin
					act  = 0;
					rel  = DEPTH_MAX;
					sens = DEPTH_MAX;
				end
				default: begin
					act = $urandom_range(1200, 3600);
					if ($urandom_range(0, 5) == 0)
						rel = $urandom_range(act, DEPTH_MAX);
					else
						rel = $urandom_range(0, act - 1);
					case ($urandom_range(0, 3))
						0: sens = $urandom_range(0, 8);
						1, 2: sens = $urandom_range(20, 300);
						default: sens = $urandom_range(301, DEPTH_MAX);
					endcase
				end
			endcase
			write_reg(REG_ACTUATION_LEVEL, depth_t'(act));
			write_reg(REG_RELEASE_LEVEL, depth_t'(rel));
			write_reg(REG_SENSITIVITY, depth_t'(sens));
			if (ph == 4)
				write_reg(REG_UNUSED, depth_t'($urandom));
			n_settings++;

			// receiver holds off while input keeps coming back to back
			if (ph == 3) begin
				hold_asks++;
				burst_left = 80;
			end

			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				if (burst_left == 0) begin
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					if (gap > 0) begin
						@(negedge clk);
						smp_ch.valid <= 1'b0;
						repeat (gap - 1) @(negedge clk);
					end
					burst_left = $urandom_range(1, 24);
				end
				burst_left--;

				if ($urandom_range(0, 99) < 12) begin
					d = depth_t'($urandom_range(0, DEPTH_MAX));
				end else begin
					if (pos == target || $urandom_range(0, 19) == 0) begin
						case ($urandom_range(0, 7))
							0: target = 0;
							1: target = DEPTH_MAX;
							default: target = $urandom_range(0, DEPTH_MAX);
						endcase
					end
					span = int'(lvl_sens) * 2 + 40;
					if (span > 1500)
						span = 1500;
					stride = $urandom_range(1, span);
					if ($urandom_range(0, 5) == 0) begin
						// small wiggle against the travel direction
						stride = stride / 2;
						pos = (target > pos) ? pos - stride : pos + stride;
					end else if (target > pos) begin
						pos = (pos + stride > target) ? target : pos + stride;
					end else begin
						pos = (pos - stride < target) ? target : pos - stride;
					end
					if (pos < 0)
						pos = 0;
					if (pos > DEPTH_MAX)
						pos = DEPTH_MAX;
					d = depth_t'(pos);
				end
				send_depth(d, 1'b0, EVENT_NONE, MODE_IDLE);
			end
		end

		drain_results();
		if (key_results_due.size() != 0) begin
			$error("%0d expected result words never arrived", key_results_due.size());
			mismatches++;
		end

		$display("run covered %0d depth words and %0d result words (%0d press, %0d release)",
			n_words, n_results, n_press, n_release);
		$display("%0d register writes over %0d threshold settings, one %0d-cycle hold-off",
			n_writes, n_settings, HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
